FILE: rtl/modbus_tcp_client_transaction_macros.svh
// Assertion macros used by the port-level monitor of the Modbus TCP client.
`ifndef MODBUS_TCP_CLIENT_TRANSACTION_MACROS_SVH
`define MODBUS_TCP_CLIENT_TRANSACTION_MACROS_SVH

// Implication checked in the same cycle.
`define MTC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Modbus TCP client assertion failed.");

// Implication checked in the following cycle.
`define MTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Modbus TCP client assertion failed.");

`endif

FILE: rtl/mtc_pkg.sv
// Types, codes and helpers shared by the Modbus TCP client modules.
package mtc_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [1:0] OUT_TX     = 2'd0;
    localparam logic [1:0] OUT_VALUE  = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_PROTOCOL = 3'd3;
    localparam logic [2:0] ST_EXCEPT   = 3'd4;

    localparam logic [1:0] FS_COILS    = 2'd0;
    localparam logic [1:0] FS_HOLDING  = 2'd1;
    localparam logic [1:0] FS_SINGLE   = 2'd2;
    localparam logic [1:0] FS_MULTIPLE = 2'd3;

    localparam int FL_ID = 0;
    localparam int FL_PX = 1;
    localparam int FL_FN = 2;
    localparam int FL_DT = 3;

    localparam logic [15:0] MAX_COILS    = 16'd2000;
    localparam logic [15:0] MAX_HOLDING  = 16'd125;
    localparam logic [15:0] MAX_MULTIPLE = 16'd123;
    localparam logic [7:0]  EXC_BIT      = 8'h80;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_HEAD,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        J_REQ,
        J_WORD,
        J_COIL,
        J_REG,
        J_STAT
    } jkind_t;

    typedef struct packed {
        jkind_t      jkind;
        logic [3:0]  nbody;
        logic        has_status;
        logic [2:0]  status;
        logic [7:0]  exc;
        logic [15:0] tid;
        logic [7:0]  unit;
        logic [1:0]  fs;
        logic [15:0] addr;
        logic [15:0] data;
        logic [10:0] idx;
    } job_t;

    function automatic logic [7:0] fcode_of(input logic [1:0] fs);
        logic [7:0] r;
        case (fs)
            FS_COILS:    r = 8'h01;
            FS_HOLDING:  r = 8'h03;
            FS_SINGLE:   r = 8'h06;
            FS_MULTIPLE: r = 8'h10;
            default:     r = 8'h01;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/mtc_queue.sv
// Short job queue between the front and back parts of the Modbus TCP client.
module mtc_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  mtc_pkg::job_t din,
    output logic         full,
    input  logic         pop,
    output mtc_pkg::job_t dout,
    output logic         empty
);
    import mtc_pkg::*;

    job_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/mtc_front.sv
// Front part: accepts input beats, tracks the transaction and queues result jobs.
module mtc_front #(
    parameter int MAX_PDU_BYTES = 253
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [1:0]    kind,
    input  logic [7:0]    unit_id,
    input  logic [1:0]    function_sel,
    input  logic [15:0]   start_address,
    input  logic [15:0]   quantity_or_value,
    input  logic [15:0]   data_word,
    input  logic [7:0]    rx_byte,
    input  logic [15:0]   timeout_ticks,
    output logic          push,
    output mtc_pkg::job_t job
);
    import mtc_pkg::*;

    localparam logic [15:0] LEN_MAX = 16'(MAX_PDU_BYTES + 1);

    logic [15:0] next_tid_reg, next_tid_next;
    logic [15:0] pend_tid_reg, pend_tid_next;
    logic [7:0]  pend_unit_reg, pend_unit_next;
    logic [1:0]  pend_fs_reg, pend_fs_next;
    logic [15:0] pend_addr_reg, pend_addr_next;
    logic [15:0] pend_qty_reg, pend_qty_next;
    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] limit_reg, limit_next;
    logic [6:0]  words_reg, words_next;
    logic [7:0]  hold_reg, hold_next;
    logic [3:0]  flags_reg, flags_next;
    logic [7:0]  last_exc_reg, last_exc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_tid_reg  <= 16'd1;
            pend_tid_reg  <= '0;
            pend_unit_reg <= '0;
            pend_fs_reg   <= '0;
            pend_addr_reg <= '0;
            pend_qty_reg  <= '0;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            flen_reg      <= '0;
            elapsed_reg   <= '0;
            limit_reg     <= 16'd1;
            words_reg     <= '0;
            hold_reg      <= '0;
            flags_reg     <= '0;
            last_exc_reg  <= '0;
        end else begin
            next_tid_reg  <= next_tid_next;
            pend_tid_reg  <= pend_tid_next;
            pend_unit_reg <= pend_unit_next;
            pend_fs_reg   <= pend_fs_next;
            pend_addr_reg <= pend_addr_next;
            pend_qty_reg  <= pend_qty_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            flen_reg      <= flen_next;
            elapsed_reg   <= elapsed_next;
            limit_reg     <= limit_next;
            words_reg     <= words_next;
            hold_reg      <= hold_next;
            flags_reg     <= flags_next;
            last_exc_reg  <= last_exc_next;
        end
    end

    always_comb begin
        logic        bad_qty;
        logic [3:0]  fl;
        logic [8:0]  pm9;
        logic [11:0] base;
        logic [15:0] diff;
        logic [7:0]  ridx;
        logic [7:0]  expect_b;
        logic [15:0] echo_w;
        logic [17:0] want_len;
        logic [2:0]  st;
        logic [7:0]  exc_v;
        logic [15:0] el_inc;
        logic [15:0] tid_inc;

        next_tid_next  = next_tid_reg;
        pend_tid_next  = pend_tid_reg;
        pend_unit_next = pend_unit_reg;
        pend_fs_next   = pend_fs_reg;
        pend_addr_next = pend_addr_reg;
        pend_qty_next  = pend_qty_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        flen_next      = flen_reg;
        elapsed_next   = elapsed_reg;
        limit_next     = limit_reg;
        words_next     = words_reg;
        hold_next      = hold_reg;
        flags_next     = flags_reg;
        last_exc_next  = last_exc_reg;
        push           = 1'b0;
        job            = '0;
        job.jkind      = J_STAT;
        job.exc        = last_exc_reg;

        bad_qty  = 1'b0;
        fl       = flags_reg;
        pm9      = pos_reg - 9'd9;
        base     = {pm9, 3'b000};
        diff     = '0;
        ridx     = pm9[8:1];
        expect_b = '0;
        echo_w   = '0;
        want_len = '0;
        st       = ST_OK;
        exc_v    = last_exc_reg;
        el_inc   = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        tid_inc  = next_tid_reg + 16'd1;

        if (accept) begin
            case (kind)
                KIND_START: begin
                    phase_next = PH_IDLE;
                    case (function_sel)
                        FS_COILS:    bad_qty = (quantity_or_value == '0) ||
                                               (quantity_or_value > MAX_COILS);
                        FS_HOLDING:  bad_qty = (quantity_or_value == '0) ||
                                               (quantity_or_value > MAX_HOLDING);
                        FS_MULTIPLE: bad_qty = (quantity_or_value == '0) ||
                                               (quantity_or_value > MAX_MULTIPLE);
                        default:     bad_qty = 1'b0;
                    endcase
                    push = 1'b1;
                    if (bad_qty) begin
                        job.jkind      = J_STAT;
                        job.has_status = 1'b1;
                        job.status     = ST_INVALID;
                    end else begin
                        next_tid_next  = (tid_inc == '0) ? 16'd1 : tid_inc;
                        pend_tid_next  = next_tid_reg;
                        pend_unit_next = unit_id;
                        pend_fs_next   = function_sel;
                        pend_addr_next = start_address;
                        pend_qty_next  = quantity_or_value;
                        limit_next     = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
                        job.jkind      = J_REQ;
                        job.tid        = next_tid_reg;
                        job.unit       = unit_id;
                        job.fs         = function_sel;
                        job.addr       = start_address;
                        job.data       = quantity_or_value;
                        if (function_sel == FS_MULTIPLE) begin
                            job.nbody  = 4'd13;
                            phase_next = PH_DATA;
                            words_next = quantity_or_value[6:0];
                        end else begin
                            job.nbody    = 4'd12;
                            phase_next   = PH_HEAD;
                            pos_next     = '0;
                            elapsed_next = '0;
                            flags_next   = '0;
                            flen_next    = '0;
                        end
                    end
                end
                KIND_WORD: begin
                    if (phase_reg == PH_DATA) begin
                        push       = 1'b1;
                        job.jkind  = J_WORD;
                        job.nbody  = 4'd2;
                        job.data   = data_word;
                        words_next = words_reg - 7'd1;
                        if (words_next == '0) begin
                            phase_next   = PH_HEAD;
                            pos_next     = '0;
                            elapsed_next = '0;
                            flags_next   = '0;
                            flen_next    = '0;
                        end
                    end
                end
                KIND_BYTE: begin
                    if (phase_reg == PH_HEAD) begin
                        pos_next = pos_reg + 9'd1;
                        case (pos_reg)
                            9'd0: if (rx_byte != pend_tid_reg[15:8]) fl[FL_ID] = 1'b1;
                            9'd1: if (rx_byte != pend_tid_reg[7:0]) fl[FL_ID] = 1'b1;
                            9'd2, 9'd3: if (rx_byte != '0) fl[FL_PX] = 1'b1;
                            9'd4: hold_next = rx_byte;
                            9'd5: flen_next = {hold_reg, rx_byte};
                            default: begin
                                if (rx_byte != pend_unit_reg) fl[FL_ID] = 1'b1;
                                if (fl[FL_PX] || (flen_reg < 16'd2) || (flen_reg > LEN_MAX)) begin
                                    phase_next     = PH_IDLE;
                                    push           = 1'b1;
                                    job.jkind      = J_STAT;
                                    job.has_status = 1'b1;
                                    job.status     = ST_PROTOCOL;
                                end else begin
                                    flen_next    = flen_reg + 16'd6;
                                    phase_next   = PH_BODY;
                                    elapsed_next = '0;
                                    pos_next     = 9'd7;
                                end
                            end
                        endcase
                        flags_next = fl;
                    end else if (phase_reg == PH_BODY) begin
                        job.jkind = J_COIL;
                        if (pos_reg == 9'd7) begin
                            if ((rx_byte & EXC_BIT) != '0) begin
                                fl[FL_PX] = 1'b1;
                            end else if (rx_byte != fcode_of(pend_fs_reg)) begin
                                fl[FL_FN] = 1'b1;
                            end
                        end else if (!fl[FL_PX] && !fl[FL_FN]) begin
                            if (pend_fs_reg == FS_COILS) begin
                                if (pos_reg == 9'd8) begin
                                    expect_b = 8'((pend_qty_reg + 16'd7) >> 3);
                                    if (rx_byte != expect_b) fl[FL_DT] = 1'b1;
                                end else if ({4'b0, base} < pend_qty_reg) begin
                                    diff      = pend_qty_reg - {4'b0, base};
                                    job.nbody = (diff >= 16'd8) ? 4'd8 : diff[3:0];
                                    job.data  = {8'b0, rx_byte};
                                    job.idx   = base[10:0];
                                end
                            end else if (pend_fs_reg == FS_HOLDING) begin
                                job.jkind = J_REG;
                                if (pos_reg == 9'd8) begin
                                    expect_b = {pend_qty_reg[6:0], 1'b0};
                                    if (rx_byte != expect_b) fl[FL_DT] = 1'b1;
                                end else if (!pm9[0]) begin
                                    hold_next = rx_byte;
                                end else if ({8'b0, ridx} < pend_qty_reg) begin
                                    job.nbody = 4'd1;
                                    job.data  = {hold_reg, rx_byte};
                                    job.idx   = {3'b0, ridx};
                                end
                            end else if (pos_reg <= 9'd11) begin
                                echo_w   = (pos_reg < 9'd10) ? pend_addr_reg : pend_qty_reg;
                                expect_b = pos_reg[0] ? echo_w[7:0] : echo_w[15:8];
                                if (rx_byte != expect_b) fl[FL_DT] = 1'b1;
                            end
                        end
                        flags_next = fl;
                        if ({7'b0, pos_reg} + 16'd1 >= flen_reg) begin
                            case (pend_fs_reg)
                                FS_COILS:   want_len = 18'd9 + 18'((pend_qty_reg + 16'd7) >> 3);
                                FS_HOLDING: want_len = 18'd9 + {1'b0, pend_qty_reg, 1'b0};
                                default:    want_len = 18'd12;
                            endcase
                            if ((flen_reg < 16'd9) || fl[FL_ID]) begin
                                st = ST_PROTOCOL;
                            end else if (fl[FL_PX]) begin
                                st = (flen_reg != 16'd9) ? ST_PROTOCOL : ST_EXCEPT;
                            end else if (fl[FL_FN]) begin
                                st = ST_PROTOCOL;
                            end else begin
                                exc_v = '0;
                                if (fl[FL_DT] || ({2'b0, flen_reg} != want_len)) begin
                                    st = ST_PROTOCOL;
                                end else begin
                                    st = ST_OK;
                                end
                            end
                            if (st == ST_EXCEPT) begin
                                exc_v = rx_byte;
                            end
                            last_exc_next  = exc_v;
                            phase_next     = PH_IDLE;
                            job.has_status = 1'b1;
                            job.status     = st;
                            job.exc        = exc_v;
                        end else begin
                            pos_next = pos_reg + 9'd1;
                        end
                        push = job.has_status || (job.nbody != '0);
                    end
                end
                default: begin
                    if ((phase_reg == PH_HEAD) || (phase_reg == PH_BODY)) begin
                        elapsed_next = el_inc;
                        if (el_inc >= limit_reg) begin
                            phase_next     = PH_IDLE;
                            push           = 1'b1;
                            job.jkind      = J_STAT;
                            job.has_status = 1'b1;
                            job.status     = ST_TIMEOUT;
                        end
                    end
                end
            endcase
        end
    end
endmodule

FILE: rtl/mtc_back.sv
// Back part: expands queued jobs into result beats behind an output register.
module mtc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  mtc_pkg::job_t head,
    input  logic          empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    import mtc_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic        valid_reg;
    logic [47:0] data_reg;
    logic [1:0]  user_reg;
    logic        last_reg;
    logic        load;
    logic [3:0]  total;
    logic        beat_last;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx;
    logic [15:0] o_val;
    logic [10:0] o_idx;
    logic [2:0]  o_st;
    logic [7:0]  o_exc;
    logic [15:0] req_len;

    assign load      = !empty && (!valid_reg || m_tready);
    assign total     = head.nbody + {3'b0, head.has_status};
    assign beat_last = (pos_reg == total - 4'd1);
    assign pop       = load && beat_last;
    assign pos_next  = pop ? 4'd0 : (load ? pos_reg + 4'd1 : pos_reg);
    assign req_len   = (head.fs == FS_MULTIPLE) ? 16'd7 + {head.data[14:0], 1'b0} : 16'd6;

    always_comb begin
        o_kind = OUT_TX;
        o_tx   = '0;
        o_val  = '0;
        o_idx  = '0;
        o_st   = ST_OK;
        o_exc  = '0;
        if (pos_reg < head.nbody) begin
            case (head.jkind)
                J_REQ: begin
                    case (pos_reg)
                        4'd0:    o_tx = head.tid[15:8];
                        4'd1:    o_tx = head.tid[7:0];
                        4'd4:    o_tx = req_len[15:8];
                        4'd5:    o_tx = req_len[7:0];
                        4'd6:    o_tx = head.unit;
                        4'd7:    o_tx = fcode_of(head.fs);
                        4'd8:    o_tx = head.addr[15:8];
                        4'd9:    o_tx = head.addr[7:0];
                        4'd10:   o_tx = head.data[15:8];
                        4'd11:   o_tx = head.data[7:0];
                        4'd12:   o_tx = {head.data[6:0], 1'b0};
                        default: o_tx = '0;
                    endcase
                end
                J_WORD: begin
                    o_tx = (pos_reg == '0) ? head.data[15:8] : head.data[7:0];
                end
                J_COIL: begin
                    o_kind = OUT_VALUE;
                    o_val  = {15'b0, head.data[pos_reg[2:0]]};
                    o_idx  = head.idx + {8'b0, pos_reg[2:0]};
                end
                J_REG: begin
                    o_kind = OUT_VALUE;
                    o_val  = head.data;
                    o_idx  = head.idx;
                end
                default: begin
                    o_kind = OUT_STATUS;
                end
            endcase
        end else begin
            o_kind = OUT_STATUS;
            o_st   = head.status;
            o_exc  = head.exc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {2'b0, o_exc, o_st, o_idx, o_val, o_tx};
            user_reg <= o_kind;
            last_reg <= beat_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;
endmodule

FILE: rtl/modbus_tcp_client_transaction.sv
// Modbus TCP client transaction engine. Input beats are taken one per cycle while the
// four-entry job queue between the front and back parts has room; each beat is decoded
// combinationally and its job is queued in the same cycle. Results leave the back part
// one beat per cycle while m_tready is high, and that output rate sets the sustained
// rate. An input item yields one output beat per result: 1 for a status, 2 for a data
// word, 12 or 13 for a request, up to 9 for a coil byte.
module modbus_tcp_client_transaction #(
    parameter int MAX_PDU_BYTES = 253
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // unit_id, function_sel, start_address, quantity_or_value, data_word, rx_byte,
    // timeout_ticks, zero fill
    input  logic [87:0] s_tdata,
    // kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte, read_value, read_index, status, exception_code, zero fill
    output logic [47:0] m_tdata,
    // out_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import mtc_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic empty;
    logic pop;
    job_t job;
    job_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    mtc_front #(
        .MAX_PDU_BYTES(MAX_PDU_BYTES)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept            (accept),
        .kind              (s_tuser),
        .unit_id           (s_tdata[7:0]),
        .function_sel      (s_tdata[9:8]),
        .start_address     (s_tdata[25:10]),
        .quantity_or_value (s_tdata[41:26]),
        .data_word         (s_tdata[57:42]),
        .rx_byte           (s_tdata[65:58]),
        .timeout_ticks     (s_tdata[81:66]),
        .push              (push),
        .job               (job)
    );

    mtc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (job),
        .full    (full),
        .pop     (pop),
        .dout    (head),
        .empty   (empty)
    );

    mtc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule

FILE: rtl/mtc_monitor.sv
// Port-level assertions for the Modbus TCP client and their binding.
`include "modbus_tcp_client_transaction_macros.svh"

module mtc_monitor (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import mtc_pkg::*;

    `MTC_ASSERT_SAME(a_kind_known, aclk, aresetn, m_tvalid, m_tuser != 2'd3)
    `MTC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MTC_ASSERT_SAME(a_status_last, aclk, aresetn, m_tvalid && (m_tuser == OUT_STATUS), m_tlast)
    `MTC_ASSERT_SAME(a_tx_clean, aclk, aresetn, m_tvalid && (m_tuser == OUT_TX), m_tdata[45:8] == '0)
endmodule

bind modbus_tcp_client_transaction mtc_monitor u_mtc_monitor (.*);

FILE: sim/modbus_tcp_client_transaction_checker.sv
// Checker that mirrors the Modbus TCP client engine and compares every output beat.
`timescale 1ns / 1ps

module modbus_tcp_client_transaction_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          beats_checked
);
    import mtc_pkg::*;

    localparam logic [7:0] FC_COILS    = 8'h01;
    localparam logic [7:0] FC_HOLDING  = 8'h03;
    localparam logic [7:0] FC_SINGLE   = 8'h06;
    localparam logic [7:0] FC_MULTIPLE = 8'h10;

    localparam int MAX_PDU_BYTES_TB = 253;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  txb;
        logic [15:0] value;
        logic [10:0] index;
        logic [2:0]  status;
        logic [7:0]  exc;
        logic        last;
    } beat_t;

    beat_t       expected_beats[$];

    logic [15:0] next_tid;
    logic [15:0] cur_tid;
    logic [7:0]  cur_unit;
    logic [1:0]  cur_fs;
    logic [15:0] cur_addr;
    logic [15:0] cur_qty;
    phase_t      phase;
    int          byte_pos;
    logic [15:0] frame_len;
    logic [15:0] ticks;
    logic [15:0] tick_limit;
    logic [6:0]  words_left;
    logic [7:0]  held_byte;
    logic [3:0]  flags;
    logic [7:0]  last_exc;

    assign pending = expected_beats.size();

    function automatic logic [7:0] func_code(input logic [1:0] fs);
        case (fs)
            FS_COILS:   return FC_COILS;
            FS_HOLDING: return FC_HOLDING;
            FS_SINGLE:  return FC_SINGLE;
            default:    return FC_MULTIPLE;
        endcase
    endfunction

    task automatic push(input logic [1:0] k, input logic [7:0] t, input logic [15:0] v,
                        input logic [10:0] i, input logic [2:0] s, input logic [7:0] e);
        beat_t b;
        b.kind = k;
        b.txb = t;
        b.value = v;
        b.index = i;
        b.status = s;
        b.exc = e;
        b.last = 1'b0;
        expected_beats.push_back(b);
    endtask

    task automatic complete(input logic [2:0] s);
        phase = PH_IDLE;
        push(OUT_STATUS, 8'd0, 16'd0, 11'd0, s, last_exc);
    endtask

    task automatic open_receive();
        phase = PH_HEAD;
        byte_pos = 0;
        ticks = 16'd0;
        flags = 4'd0;
        frame_len = 16'd0;
    endtask

    task automatic judge_frame(output logic [2:0] s);
        int fl;
        int q;
        fl = frame_len;
        q = cur_qty;
        if (fl < 9 || flags[FL_ID]) s = ST_PROTOCOL;
        else if (flags[FL_PX]) s = (fl != 9) ? ST_PROTOCOL : ST_EXCEPT;
        else if (flags[FL_FN]) s = ST_PROTOCOL;
        else begin
            last_exc = 8'd0;
            if (flags[FL_DT]) s = ST_PROTOCOL;
            else if (cur_fs == FS_COILS) s = (fl == 9 + ((q + 7) >> 3)) ? ST_OK : ST_PROTOCOL;
            else if (cur_fs == FS_HOLDING) s = (fl == 9 + 2 * q) ? ST_OK : ST_PROTOCOL;
            else s = (fl == 12) ? ST_OK : ST_PROTOCOL;
        end
    endtask

    task automatic header_byte(input logic [7:0] b);
        int len;
        if (byte_pos == 0 && b != cur_tid[15:8]) flags[FL_ID] = 1'b1;
        if (byte_pos == 1 && b != cur_tid[7:0]) flags[FL_ID] = 1'b1;
        if ((byte_pos == 2 || byte_pos == 3) && b != 8'd0) flags[FL_PX] = 1'b1;
        if (byte_pos == 4) held_byte = b;
        if (byte_pos == 5) frame_len = {held_byte, b};
        if (byte_pos >= 6) begin
            len = frame_len;
            if (b != cur_unit) flags[FL_ID] = 1'b1;
            if (flags[FL_PX] || len < 2 || len > MAX_PDU_BYTES_TB + 1) begin
                complete(ST_PROTOCOL);
            end else begin
                frame_len = 16'(6 + len);
                phase = PH_BODY;
                ticks = 16'd0;
                byte_pos = 7;
            end
        end else begin
            byte_pos = byte_pos + 1;
        end
    endtask

    task automatic body_byte(input logic [7:0] b);
        int p;
        int q;
        int base;
        int k;
        logic [15:0] w;
        logic [7:0] e;
        logic [2:0] s;
        p = byte_pos;
        q = cur_qty;
        if (p == 7) begin
            if (b[7]) flags[FL_PX] = 1'b1;
            else if (b != func_code(cur_fs)) flags[FL_FN] = 1'b1;
        end else if (!flags[FL_PX] && !flags[FL_FN]) begin
            if (cur_fs == FS_COILS) begin
                if (p == 8) begin
                    if (b != 8'((q + 7) >> 3)) flags[FL_DT] = 1'b1;
                end else begin
                    base = (p - 9) * 8;
                    for (int i = 0; i < 8; i++)
                        if (base + i < q)
                            push(OUT_VALUE, 8'd0, 16'(b[i]), 11'(base + i), 3'd0, 8'd0);
                end
            end else if (cur_fs == FS_HOLDING) begin
                if (p == 8) begin
                    if (b != 8'(q * 2)) flags[FL_DT] = 1'b1;
                end else if (((p - 9) & 1) == 0) begin
                    held_byte = b;
                end else if (((p - 9) >> 1) < q) begin
                    push(OUT_VALUE, 8'd0, {held_byte, b}, 11'((p - 9) >> 1), 3'd0, 8'd0);
                end
            end else if (p <= 11) begin
                k = p - 8;
                w = (k < 2) ? cur_addr : cur_qty;
                e = ((k & 1) == 0) ? w[15:8] : w[7:0];
                if (b != e) flags[FL_DT] = 1'b1;
            end
        end
        if (p + 1 >= frame_len) begin
            judge_frame(s);
            if (s == ST_EXCEPT) last_exc = b;
            complete(s);
        end else begin
            byte_pos = p + 1;
        end
    endtask

    task automatic start_request(input logic [87:0] d);
        logic [7:0]  unit;
        logic [1:0]  fs;
        logic [15:0] addr;
        logic [15:0] q;
        logic [15:0] tmo;
        logic [15:0] len;
        logic [15:0] tid;
        unit = d[7:0];
        fs = d[9:8];
        addr = d[25:10];
        q = d[41:26];
        tmo = d[81:66];
        phase = PH_IDLE;
        if ((fs == FS_COILS && (q == 0 || q > MAX_COILS)) ||
            (fs == FS_HOLDING && (q == 0 || q > MAX_HOLDING)) ||
            (fs == FS_MULTIPLE && (q == 0 || q > MAX_MULTIPLE))) begin
            complete(ST_INVALID);
        end else begin
            tid = next_tid;
            next_tid = tid + 16'd1;
            if (next_tid == 16'd0) next_tid = 16'd1;
            cur_tid = tid;
            cur_unit = unit;
            cur_fs = fs;
            cur_addr = addr;
            cur_qty = q;
            tick_limit = (tmo == 0) ? 16'd1 : tmo;
            len = (fs == FS_MULTIPLE) ? 16'(7 + 2 * q) : 16'd6;
            push(OUT_TX, tid[15:8], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, tid[7:0], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, 8'd0, 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, 8'd0, 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, len[15:8], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, len[7:0], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, unit, 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, func_code(fs), 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, addr[15:8], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, addr[7:0], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, q[15:8], 16'd0, 11'd0, 3'd0, 8'd0);
            push(OUT_TX, q[7:0], 16'd0, 11'd0, 3'd0, 8'd0);
            if (fs == FS_MULTIPLE) begin
                push(OUT_TX, 8'(2 * q), 16'd0, 11'd0, 3'd0, 8'd0);
                phase = PH_DATA;
                words_left = q[6:0];
            end else begin
                open_receive();
            end
        end
    endtask

    task automatic advance_engine(input logic [1:0] kind, input logic [87:0] d);
        int size0;
        size0 = expected_beats.size();
        case (kind)
            KIND_START: start_request(d);
            KIND_WORD: begin
                if (phase == PH_DATA) begin
                    push(OUT_TX, d[57:50], 16'd0, 11'd0, 3'd0, 8'd0);
                    push(OUT_TX, d[49:42], 16'd0, 11'd0, 3'd0, 8'd0);
                    words_left = words_left - 7'd1;
                    if (words_left == 7'd0) open_receive();
                end
            end
            KIND_BYTE: begin
                if (phase == PH_HEAD) header_byte(d[65:58]);
                else if (phase == PH_BODY) body_byte(d[65:58]);
            end
            default: begin
                if (phase == PH_HEAD || phase == PH_BODY) begin
                    if (ticks < 16'hFFFF) ticks = ticks + 16'd1;
                    if (ticks >= tick_limit) complete(ST_TIMEOUT);
                end
            end
        endcase
        if (expected_beats.size() > size0)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        beat_t b;
        if (!aresetn) begin
            expected_beats.delete();
            errors <= 0;
            beats_checked <= 0;
            next_tid = 16'd1;
            cur_tid = 16'd0;
            cur_unit = 8'd0;
            cur_fs = 2'd0;
            cur_addr = 16'd0;
            cur_qty = 16'd0;
            phase = PH_IDLE;
            byte_pos = 0;
            frame_len = 16'd0;
            ticks = 16'd0;
            tick_limit = 16'd1;
            words_left = 7'd0;
            held_byte = 8'd0;
            flags = 4'd0;
            last_exc = 8'd0;
        end else begin
            if (s_tvalid && s_tready) advance_engine(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                beats_checked <= beats_checked + 1;
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat kind=%0d data=%h last=%b",
                             $time, m_tuser, m_tdata, m_tlast);
                    errors <= errors + 1;
                end else begin
                    b = expected_beats.pop_front();
                    if (m_tuser !== b.kind || m_tdata[7:0] !== b.txb ||
                        m_tdata[23:8] !== b.value || m_tdata[34:24] !== b.index ||
                        m_tdata[37:35] !== b.status || m_tdata[45:38] !== b.exc ||
                        m_tdata[47:46] !== 2'd0 || m_tlast !== b.last) begin
                        $display({"%0t: mismatch expected kind=%0d tx=%h val=%h idx=%0d",
                                  " st=%0d exc=%h last=%b"},
                                 $time, b.kind, b.txb, b.value, b.index, b.status, b.exc,
                                 b.last);
                        $display({"%0t:          actual kind=%0d tx=%h val=%h idx=%0d",
                                  " st=%0d exc=%h last=%b"},
                                 $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[34:24],
                                 m_tdata[37:35], m_tdata[45:38], m_tlast);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the Modbus TCP client engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import mtc_pkg::*;

    localparam int MODE_GOOD    = 0;
    localparam int MODE_CORRUPT = 1;
    localparam int MODE_EXCEPT  = 2;
    localparam int MODE_TIMEOUT = 3;
    localparam int MODE_ABANDON = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          errors;
    int          pending;
    int          beats_checked;
    int          items = 0;
    int          txns = 0;
    int          s_idle = 0;
    int          r_idle = 0;
    logic [15:0] next_tid = 16'd1;

    modbus_tcp_client_transaction dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    modbus_tcp_client_transaction_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .errors(errors), .pending(pending), .beats_checked(beats_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= r_idle);

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [87:0] random_fill();
        logic [87:0] d;
        d = 88'({$urandom, $urandom, $urandom});
        d[87:82] = 6'd0;
        return d;
    endfunction

    task automatic send(input logic [1:0] k, input logic [87:0] d);
        while ($urandom_range(0, 99) < s_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [87:0] d;
        d = random_fill();
        d[65:58] = b;
        send(KIND_BYTE, d);
    endtask

    task automatic send_word(input logic [15:0] w);
        logic [87:0] d;
        d = random_fill();
        d[57:42] = w;
        send(KIND_WORD, d);
    endtask

    task automatic send_tick();
        send(KIND_TICK, random_fill());
    endtask

    task automatic take_tid(output logic [15:0] tid);
        tid = next_tid;
        next_tid = next_tid + 16'd1;
        if (next_tid == 16'd0) next_tid = 16'd1;
    endtask

    function automatic bit qty_ok(input logic [1:0] fs, input logic [15:0] q);
        if (fs == FS_COILS) return q != 0 && q <= MAX_COILS;
        if (fs == FS_HOLDING) return q != 0 && q <= MAX_HOLDING;
        if (fs == FS_MULTIPLE) return q != 0 && q <= MAX_MULTIPLE;
        return 1'b1;
    endfunction

    // One request and its response, well formed or broken according to mode.
    task automatic run_txn(input logic [1:0] fs, input logic [15:0] q, input int mode);
        logic [87:0] d;
        logic [7:0]  frame[$];
        logic [7:0]  fc;
        logic [7:0]  unit;
        logic [15:0] addr;
        logic [15:0] tmo;
        logic [15:0] tid;
        int          bc;
        int          len;
        int          cut;
        int          pos;
        unit = 8'($urandom);
        addr = 16'($urandom);
        tmo = (mode == MODE_TIMEOUT) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(2000, 65535));
        d = random_fill();
        d[7:0] = unit;
        d[9:8] = fs;
        d[25:10] = addr;
        d[41:26] = q;
        d[81:66] = tmo;
        send(KIND_START, d);
        txns++;
        if (!qty_ok(fs, q)) return;
        take_tid(tid);
        if (fs == FS_MULTIPLE)
            for (int i = 0; i < q; i++) send_word(16'($urandom));
        if (mode == MODE_TIMEOUT) begin
            if ($urandom_range(0, 1)) send_byte(tid[15:8]);
            repeat ((tmo == 0) ? 1 : tmo) send_tick();
            return;
        end
        fc = fcode_of(fs);
        if (mode == MODE_EXCEPT) begin
            fc = fc | EXC_BIT;
            len = 3;
        end else if (fs == FS_COILS) begin
            bc = (q + 7) / 8;
            len = 3 + bc;
        end else if (fs == FS_HOLDING) begin
            bc = 2 * q;
            len = 3 + bc;
        end else begin
            len = 6;
        end
        frame = {tid[15:8], tid[7:0], 8'd0, 8'd0, 8'(len >> 8), 8'(len), unit, fc};
        if (mode == MODE_EXCEPT) frame.push_back(8'($urandom));
        else if (fs == FS_COILS || fs == FS_HOLDING) begin
            frame.push_back(8'(bc));
            for (int i = 0; i < bc; i++) frame.push_back(8'($urandom));
        end else begin
            frame.push_back(addr[15:8]);
            frame.push_back(addr[7:0]);
            frame.push_back(q[15:8]);
            frame.push_back(q[7:0]);
        end
        if (mode == MODE_CORRUPT) begin
            pos = $urandom_range(0, frame.size() - 1);
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
        end
        cut = (mode == MODE_ABANDON) ? $urandom_range(0, frame.size() - 1) : frame.size();
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 9) == 0) send_tick();
            send_byte(frame[i]);
        end
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom));
    endtask

    task automatic random_txn();
        logic [1:0]  fs;
        logic [15:0] q;
        logic [87:0] d;
        logic [1:0]  k;
        logic [15:0] tid;
        int          r;
        int          mode;
        fs = 2'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) q = ($urandom_range(0, 1)) ? 16'd0 : 16'($urandom);
        else if (r < 12) q = 16'($urandom_range(11, 40));
        else q = 16'($urandom_range(1, 10));
        if (fs == FS_SINGLE) q = 16'($urandom);
        r = $urandom_range(0, 99);
        mode = (r < 60) ? MODE_GOOD : (r < 75) ? MODE_CORRUPT : (r < 85) ? MODE_EXCEPT :
               (r < 93) ? MODE_TIMEOUT : MODE_ABANDON;
        if ($urandom_range(0, 9) == 0) begin
            k = 2'($urandom);
            d = random_fill();
            send(k, d);
            if (k == KIND_START && qty_ok(d[9:8], d[41:26])) take_tid(tid);
        end
        run_txn(fs, q, mode);
    endtask

    initial begin
        int          goal;
        int          third;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bad quantities, then beats that the idle engine must ignore.
        run_txn(FS_COILS, 16'd0, MODE_GOOD);
        run_txn(FS_COILS, 16'd2001, MODE_GOOD);
        run_txn(FS_HOLDING, 16'd126, MODE_GOOD);
        run_txn(FS_MULTIPLE, 16'd124, MODE_GOOD);
        run_txn(FS_MULTIPLE, 16'hFFFF, MODE_GOOD);
        send_word(16'hFFFF);
        send_byte(8'hFF);
        send_tick();
        run_txn(FS_SINGLE, 16'hFFFF, MODE_GOOD);
        run_txn(FS_SINGLE, 16'h0000, MODE_EXCEPT);
        run_txn(FS_COILS, 16'd1, MODE_GOOD);
        run_txn(FS_HOLDING, 16'd1, MODE_TIMEOUT);
        run_txn(FS_MULTIPLE, 16'd1, MODE_GOOD);
        run_txn(FS_COILS, 16'd9, MODE_ABANDON);
        run_txn(FS_COILS, MAX_COILS, MODE_EXCEPT);
        run_txn(FS_HOLDING, MAX_HOLDING, MODE_EXCEPT);
        run_txn(FS_MULTIPLE, MAX_MULTIPLE, MODE_TIMEOUT);

        goal = 330;
        third = (goal > items) ? (goal - items) / 3 : 0;
        s_idle = 7;
        r_idle = 76;
        while (items < goal - 2 * third) random_txn();
        // Let the engine drain completely before the pacing changes.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        s_idle = 76;
        r_idle = 7;
        while (items < goal - third) random_txn();
        s_idle = 0;
        r_idle = 0;
        while (items < goal) random_txn();
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d input beats over %0d requests; checked %0d output beats.",
                 items, txns, beats_checked);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
